// File: rtl/stl_pkg.sv
// Package for the source tokenizer: character codes, token kinds, status codes,
// the byte class record and the operator lookup functions.
// No dependencies.
package stl_pkg;

	localparam int unsigned OFFSET_BITS   = 32;
	localparam int unsigned POSITION_BITS = 16;
	localparam int unsigned QUEUE_DEPTH   = 4;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// token kinds
	localparam logic [5:0] K_ID      = 6'd0;
	localparam logic [5:0] K_STRING  = 6'd2;
	localparam logic [5:0] K_NUMBER  = 6'd3;
	localparam logic [5:0] K_ADD     = 6'd4;
	localparam logic [5:0] K_SUB     = 6'd5;
	localparam logic [5:0] K_MUL     = 6'd6;
	localparam logic [5:0] K_DIV     = 6'd7;
	localparam logic [5:0] K_MOD     = 6'd8;
	localparam logic [5:0] K_ASSIGN  = 6'd9;
	localparam logic [5:0] K_EQ      = 6'd10;
	localparam logic [5:0] K_GE      = 6'd12;
	localparam logic [5:0] K_LE      = 6'd13;
	localparam logic [5:0] K_GT      = 6'd14;
	localparam logic [5:0] K_LT      = 6'd15;
	localparam logic [5:0] K_LAND    = 6'd16;
	localparam logic [5:0] K_LOR     = 6'd17;
	localparam logic [5:0] K_INC     = 6'd18;
	localparam logic [5:0] K_DEC     = 6'd19;
	localparam logic [5:0] K_ADD_ASN = 6'd20;
	localparam logic [5:0] K_SUB_ASN = 6'd21;
	localparam logic [5:0] K_MUL_ASN = 6'd22;
	localparam logic [5:0] K_DIV_ASN = 6'd23;
	localparam logic [5:0] K_MOD_ASN = 6'd24;
	localparam logic [5:0] K_SEMI    = 6'd25;
	localparam logic [5:0] K_COMMA   = 6'd26;
	localparam logic [5:0] K_LBRACK  = 6'd27;
	localparam logic [5:0] K_RBRACK  = 6'd28;
	localparam logic [5:0] K_LPAREN  = 6'd29;
	localparam logic [5:0] K_RPAREN  = 6'd30;
	localparam logic [5:0] K_LBRACE  = 6'd31;
	localparam logic [5:0] K_RBRACE  = 6'd32;
	localparam logic [5:0] K_COLON   = 6'd33;
	localparam logic [5:0] K_DOT     = 6'd34;
	localparam logic [5:0] K_ARROW   = 6'd35;
	localparam logic [5:0] K_EOF     = 6'd36;
	localparam logic [5:0] K_NONE    = 6'd63;

	// status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADCHAR  = 2'd1;
	localparam logic [1:0] ST_LONE_AMP = 2'd2;
	localparam logic [1:0] ST_LONE_BAR = 2'd3;

	typedef struct packed {
		logic [7:0] ch;
		logic       zero;
		logic       nl;
		logic       ws;
		logic       id_start;
		logic       id_char;
		logic       digit;
		logic       dot;
		logic       quote;
		logic       slash;
		logic       star;
		logic       op_start;
		logic [5:0] single_kind;
	} fe_item_t;

	function automatic logic [5:0] single_kind(input logic [7:0] b);
		logic [5:0] k;
		k = K_NONE;
		unique case (b)
			CH_SEMI:   k = K_SEMI;
			CH_COMMA:  k = K_COMMA;
			CH_LBRACK: k = K_LBRACK;
			CH_RBRACK: k = K_RBRACK;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_COLON:  k = K_COLON;
			CH_DOT:    k = K_DOT;
			default:   k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] op_alone(input logic [7:0] c);
		logic [5:0] k;
		k = K_NONE;
		unique case (c)
			CH_PLUS:  k = K_ADD;
			CH_MINUS: k = K_SUB;
			CH_STAR:  k = K_MUL;
			CH_SLASH: k = K_DIV;
			CH_PCT:   k = K_MOD;
			CH_EQ:    k = K_ASSIGN;
			CH_GT:    k = K_GT;
			CH_LT:    k = K_LT;
			default:  k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] op_pair(input logic [7:0] c, input logic [7:0] b);
		logic [5:0] k;
		k = K_NONE;
		if (b == CH_EQ) begin
			unique case (c)
				CH_PLUS:  k = K_ADD_ASN;
				CH_MINUS: k = K_SUB_ASN;
				CH_STAR:  k = K_MUL_ASN;
				CH_SLASH: k = K_DIV_ASN;
				CH_PCT:   k = K_MOD_ASN;
				CH_EQ:    k = K_EQ;
				CH_GT:    k = K_GE;
				CH_LT:    k = K_LE;
				default:  k = K_NONE;
			endcase
		end else if (c == CH_PLUS && b == CH_PLUS) begin
			k = K_INC;
		end else if (c == CH_MINUS && b == CH_MINUS) begin
			k = K_DEC;
		end else if (c == CH_MINUS && b == CH_GT) begin
			k = K_ARROW;
		end else if (c == CH_AMP && b == CH_AMP) begin
			k = K_LAND;
		end else if (c == CH_BAR && b == CH_BAR) begin
			k = K_LOR;
		end
		return k;
	endfunction

endpackage

// File: rtl/stl_fifo.sv
// Small first-in first-out queue in flip-flops, used between the tokenizer stages.
// No dependencies.
module stl_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             wr_ok;
	logic             rd_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign wr_ok   = wr_en & ~full;
	assign rd_ok   = rd_en & ~empty;

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_ok && !rd_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_ok && !wr_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/stl_front.sv
// Tokenizer front end: takes source bytes and classifies each into a class record
// for the input queue. Depends on stl_pkg.
module stl_front (
	input  logic              push,
	output logic              full,
	input  logic [7:0]        source_byte,
	input  logic              q_full,
	output logic              q_push,
	output stl_pkg::fe_item_t q_item
);

	logic [7:0] b;
	logic       alpha;
	logic       digit;

	assign b      = source_byte;
	assign full   = q_full;
	assign q_push = push & ~q_full;

	assign alpha = (b >= stl_pkg::CH_LC_A && b <= stl_pkg::CH_LC_Z) ||
		(b >= stl_pkg::CH_UC_A && b <= stl_pkg::CH_UC_Z);
	assign digit = (b >= stl_pkg::CH_0 && b <= stl_pkg::CH_9);

	always_comb begin
		q_item             = '0;
		q_item.ch          = b;
		q_item.zero        = (b == stl_pkg::CH_NUL);
		q_item.nl          = (b == stl_pkg::CH_NL);
		q_item.ws          = (b == stl_pkg::CH_NL) || (b == stl_pkg::CH_SPACE);
		q_item.id_start    = alpha || (b == stl_pkg::CH_US);
		q_item.id_char     = alpha || digit || (b == stl_pkg::CH_US);
		q_item.digit       = digit;
		q_item.dot         = (b == stl_pkg::CH_DOT);
		q_item.quote       = (b == stl_pkg::CH_QUOTE);
		q_item.slash       = (b == stl_pkg::CH_SLASH);
		q_item.star        = (b == stl_pkg::CH_STAR);
		q_item.op_start    = (stl_pkg::op_alone(b) != stl_pkg::K_NONE) ||
			(b == stl_pkg::CH_AMP) || (b == stl_pkg::CH_BAR);
		q_item.single_kind = stl_pkg::single_kind(b);
	end

endmodule

// File: rtl/stl_back.sv
// Tokenizer back end: the scanning state machine. Consumes one classified byte
// per cycle while the byte queue is not empty and the token queue is not full,
// and writes the one or two tokens it ends as one record. Depends on stl_pkg.
module stl_back #(
	parameter int unsigned OFFSET_BITS   = stl_pkg::OFFSET_BITS,
	parameter int unsigned POSITION_BITS = stl_pkg::POSITION_BITS,
	localparam int unsigned RW           = 8 + OFFSET_BITS + 3 * POSITION_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stl_pkg::fe_item_t in_item,
	input  logic              in_empty,
	output logic              in_pop,
	input  logic              pair_full,
	output logic              pair_push,
	output logic [2*RW:0]     pair_data
);

	localparam int unsigned OB = OFFSET_BITS;
	localparam int unsigned PB = POSITION_BITS;

	localparam logic [2:0] MODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_IDENT    = 3'd1;
	localparam logic [2:0] MODE_NUMBER   = 3'd2;
	localparam logic [2:0] MODE_STRING   = 3'd3;
	localparam logic [2:0] MODE_OP       = 3'd4;
	localparam logic [2:0] MODE_LINECMT  = 3'd5;
	localparam logic [2:0] MODE_BLOCKCMT = 3'd6;
	localparam logic [2:0] MODE_ERROR    = 3'd7;

	function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	logic [2:0]    mode_q, mode_d;
	logic [7:0]    pend_q, pend_d;
	logic          dot_q, dot_d;
	logic          star_q, star_d;
	logic [OB-1:0] off_q, off_d;
	logic [PB-1:0] line_q, line_d;
	logic [PB-1:0] col_q, col_d;
	logic [OB-1:0] tok_off_q, tok_off_d;
	logic [PB-1:0] tok_line_q, tok_line_d;
	logic [PB-1:0] tok_col_q, tok_col_d;
	logic [PB-1:0] tok_len_q, tok_len_d;

	logic          go;
	logic          fresh;
	logic          e0;
	logic [5:0]    e0_kind;
	logic [1:0]    e0_st;
	logic [PB-1:0] e0_len;
	logic          ef;
	logic [5:0]    ef_kind;
	logic [1:0]    ef_st;
	logic [PB-1:0] ef_len;
	logic [5:0]    pk;
	logic [RW-1:0] r_tok;
	logic [RW-1:0] r_here;
	stl_pkg::fe_item_t it;

	assign it     = in_item;
	assign go     = ~in_empty & ~pair_full;
	assign in_pop = go;
	assign pk     = stl_pkg::op_pair(pend_q, it.ch);

	always_comb begin
		mode_d     = mode_q;
		pend_d     = pend_q;
		dot_d      = dot_q;
		star_d     = star_q;
		off_d      = off_q;
		line_d     = line_q;
		col_d      = col_q;
		tok_off_d  = tok_off_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		tok_len_d  = tok_len_q;
		fresh      = 1'b0;
		e0         = 1'b0;
		e0_kind    = stl_pkg::K_ID;
		e0_st      = stl_pkg::ST_OK;
		e0_len     = tok_len_q;
		ef         = 1'b0;
		ef_kind    = stl_pkg::K_ID;
		ef_st      = stl_pkg::ST_OK;
		ef_len     = PB'(1);

		unique case (mode_q)
			MODE_IDENT: begin
				if (it.id_char) begin
					tok_len_d = sat_inc(tok_len_q);
				end else begin
					e0      = 1'b1;
					e0_kind = stl_pkg::K_ID;
					fresh   = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (it.digit) begin
					tok_len_d = sat_inc(tok_len_q);
				end else if (it.dot && !dot_q) begin
					dot_d     = 1'b1;
					tok_len_d = sat_inc(tok_len_q);
				end else begin
					e0      = 1'b1;
					e0_kind = stl_pkg::K_NUMBER;
					fresh   = 1'b1;
				end
			end
			MODE_STRING: begin
				if (it.quote) begin
					e0      = 1'b1;
					e0_kind = stl_pkg::K_STRING;
					mode_d  = MODE_IDLE;
				end else if (it.zero) begin
					e0      = 1'b1;
					e0_kind = stl_pkg::K_STRING;
					fresh   = 1'b1;
				end else begin
					tok_len_d = sat_inc(tok_len_q);
				end
			end
			MODE_OP: begin
				if (pk != stl_pkg::K_NONE) begin
					e0        = 1'b1;
					e0_kind   = pk;
					e0_len    = PB'(2);
					tok_len_d = PB'(2);
					mode_d    = MODE_IDLE;
				end else if (pend_q == stl_pkg::CH_SLASH && it.slash) begin
					mode_d = MODE_LINECMT;
				end else if (pend_q == stl_pkg::CH_SLASH && it.star) begin
					star_d = 1'b0;
					mode_d = MODE_BLOCKCMT;
				end else if (pend_q == stl_pkg::CH_AMP || pend_q == stl_pkg::CH_BAR) begin
					e0      = 1'b1;
					e0_kind = stl_pkg::K_ID;
					e0_st   = (pend_q == stl_pkg::CH_AMP) ? stl_pkg::ST_LONE_AMP :
						stl_pkg::ST_LONE_BAR;
					e0_len  = PB'(1);
					if (it.zero) begin
						fresh = 1'b1;
					end else begin
						mode_d = MODE_ERROR;
					end
				end else begin
					e0      = 1'b1;
					e0_kind = stl_pkg::op_alone(pend_q);
					fresh   = 1'b1;
				end
			end
			MODE_LINECMT: begin
				if (it.nl) begin
					mode_d = MODE_IDLE;
				end else if (it.zero) begin
					fresh = 1'b1;
				end
			end
			MODE_BLOCKCMT: begin
				if (star_q && it.slash) begin
					mode_d = MODE_IDLE;
				end else if (it.zero) begin
					fresh = 1'b1;
				end else begin
					star_d = it.star;
				end
			end
			MODE_ERROR: begin
				if (it.zero) begin
					fresh = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		if (fresh) begin
			mode_d = MODE_IDLE;
			if (it.zero) begin
				ef      = 1'b1;
				ef_kind = stl_pkg::K_EOF;
				ef_len  = '0;
			end else if (it.ws) begin
				ef = 1'b0;
			end else if (it.id_start) begin
				tok_off_d  = off_q;
				tok_line_d = line_q;
				tok_col_d  = col_q;
				tok_len_d  = PB'(1);
				mode_d     = MODE_IDENT;
			end else if (it.digit) begin
				tok_off_d  = off_q;
				tok_line_d = line_q;
				tok_col_d  = col_q;
				tok_len_d  = PB'(1);
				dot_d      = 1'b0;
				mode_d     = MODE_NUMBER;
			end else if (it.quote) begin
				tok_off_d  = off_q + 1'b1;
				tok_line_d = line_q;
				tok_col_d  = sat_inc(col_q);
				tok_len_d  = '0;
				mode_d     = MODE_STRING;
			end else if (it.single_kind != stl_pkg::K_NONE) begin
				ef      = 1'b1;
				ef_kind = it.single_kind;
			end else if (it.op_start) begin
				tok_off_d  = off_q;
				tok_line_d = line_q;
				tok_col_d  = col_q;
				tok_len_d  = PB'(1);
				pend_d     = it.ch;
				mode_d     = MODE_OP;
			end else begin
				ef     = 1'b1;
				ef_st  = stl_pkg::ST_BADCHAR;
				mode_d = MODE_ERROR;
			end
		end

		if (it.zero) begin
			mode_d     = MODE_IDLE;
			pend_d     = '0;
			dot_d      = 1'b0;
			star_d     = 1'b0;
			off_d      = '0;
			line_d     = '0;
			col_d      = '0;
			tok_off_d  = '0;
			tok_line_d = '0;
			tok_col_d  = '0;
			tok_len_d  = '0;
		end else begin
			off_d = off_q + 1'b1;
			if (it.nl) begin
				line_d = sat_inc(line_q);
				col_d  = '0;
			end else begin
				col_d = sat_inc(col_q);
			end
		end
	end

	assign r_tok  = {e0_kind, e0_st, tok_off_q, e0_len, tok_line_q, tok_col_q};
	assign r_here = {ef_kind, ef_st, off_q, ef_len, line_q, col_q};

	assign pair_push = go & (e0 | ef);
	assign pair_data = e0 ? {ef, r_here, r_tok} : {1'b0, r_here, r_here};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pend_q     <= '0;
			dot_q      <= 1'b0;
			star_q     <= 1'b0;
			off_q      <= '0;
			line_q     <= '0;
			col_q      <= '0;
			tok_off_q  <= '0;
			tok_line_q <= '0;
			tok_col_q  <= '0;
			tok_len_q  <= '0;
		end else if (go) begin
			mode_q     <= mode_d;
			pend_q     <= pend_d;
			dot_q      <= dot_d;
			star_q     <= star_d;
			off_q      <= off_d;
			line_q     <= line_d;
			col_q      <= col_d;
			tok_off_q  <= tok_off_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
			tok_len_q  <= tok_len_d;
		end
	end

endmodule

// File: rtl/stl_out.sv
// Tokenizer output stage: splits each queued record of one or two tokens into
// single result beats and marks the last beat of each source byte.
// Depends on stl_pkg.
module stl_out #(
	parameter int unsigned OFFSET_BITS   = stl_pkg::OFFSET_BITS,
	parameter int unsigned POSITION_BITS = stl_pkg::POSITION_BITS,
	localparam int unsigned RW           = 8 + OFFSET_BITS + 3 * POSITION_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2*RW:0]            pair_data,
	input  logic                     pair_empty,
	output logic                     pair_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic [5:0]               token_kind,
	output logic [1:0]               status,
	output logic [OFFSET_BITS-1:0]   start_offset,
	output logic [POSITION_BITS-1:0] token_length,
	output logic [POSITION_BITS-1:0] line_number,
	output logic [POSITION_BITS-1:0] column_number,
	output logic                     last_of_run
);

	localparam int unsigned OB = OFFSET_BITS;
	localparam int unsigned PB = POSITION_BITS;

	logic          sel_q;
	logic          has2;
	logic [RW-1:0] r;
	logic          take;

	assign has2 = pair_data[2*RW];
	assign r    = sel_q ? pair_data[2*RW-1:RW] : pair_data[RW-1:0];

	assign token_kind    = r[RW-1 -: 6];
	assign status        = r[RW-7 -: 2];
	assign start_offset  = r[3*PB+OB-1 -: OB];
	assign token_length  = r[3*PB-1 -: PB];
	assign line_number   = r[2*PB-1 -: PB];
	assign column_number = r[PB-1:0];
	assign last_of_run   = sel_q | ~has2;

	assign empty    = pair_empty;
	assign take     = pop & ~pair_empty;
	assign pair_pop = take & (sel_q | ~has2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= ~sel_q & has2;
		end
	end

endmodule

// File: rtl/source_tokenizer.sv
// Top level of the source tokenizer: front end, input queue, scanning back end,
// token queue and output stage. Depends on stl_pkg, stl_fifo, stl_front,
// stl_back and stl_out.
//
// Usage: source bytes enter on source_byte with push/full; a byte is taken at a
// rising edge with push high and full low. Byte 0 ends a text: it yields the
// end-of-input token and returns all positions to zero for the next text.
// Tokens leave with empty/pop; the oldest token is on the result ports while
// empty is low and is taken at an edge with pop high. One byte yields zero, one
// or two tokens; last_of_run marks the final token of a byte.
// Latency: a byte is held in the input queue, its tokens in the token queue;
// both are registered. Throughput: one byte per cycle while the token queue
// has room, set by the scan state update; two tokens take two output beats.
// A four-entry queue sits between front and back and another holds token
// records, so a stalled receiver fills the token queue, then the byte queue,
// and only then raises full. Reset empties both queues and returns the scanner
// to idle at offset, line and column zero.
module source_tokenizer #(
	parameter int unsigned OFFSET_BITS   = stl_pkg::OFFSET_BITS,
	parameter int unsigned POSITION_BITS = stl_pkg::POSITION_BITS,
	parameter int unsigned QUEUE_DEPTH   = stl_pkg::QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [7:0]               source_byte,
	output logic                     empty,
	input  logic                     pop,
	output logic [5:0]               token_kind,
	output logic [1:0]               status,
	output logic [OFFSET_BITS-1:0]   start_offset,
	output logic [POSITION_BITS-1:0] token_length,
	output logic [POSITION_BITS-1:0] line_number,
	output logic [POSITION_BITS-1:0] column_number,
	output logic                     last_of_run
);

	localparam int unsigned RW = 8 + OFFSET_BITS + 3 * POSITION_BITS;
	localparam int unsigned IW = $bits(stl_pkg::fe_item_t);

	logic              in_q_full;
	logic              in_q_push;
	stl_pkg::fe_item_t in_q_wdata;
	stl_pkg::fe_item_t in_q_rdata;
	logic              in_q_empty;
	logic              in_q_pop;
	logic              pair_full;
	logic              pair_push;
	logic [2*RW:0]     pair_wdata;
	logic [2*RW:0]     pair_rdata;
	logic              pair_empty;
	logic              pair_pop;

	stl_front u_front (
		.push        (push),
		.full        (full),
		.source_byte (source_byte),
		.q_full      (in_q_full),
		.q_push      (in_q_push),
		.q_item      (in_q_wdata)
	);

	stl_fifo #(
		.WIDTH (IW),
		.DEPTH (QUEUE_DEPTH)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_q_push),
		.wr_data (in_q_wdata),
		.full    (in_q_full),
		.rd_en   (in_q_pop),
		.rd_data (in_q_rdata),
		.empty   (in_q_empty)
	);

	stl_back #(
		.OFFSET_BITS   (OFFSET_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_q_rdata),
		.in_empty  (in_q_empty),
		.in_pop    (in_q_pop),
		.pair_full (pair_full),
		.pair_push (pair_push),
		.pair_data (pair_wdata)
	);

	stl_fifo #(
		.WIDTH (2 * RW + 1),
		.DEPTH (QUEUE_DEPTH)
	) u_tok_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pair_push),
		.wr_data (pair_wdata),
		.full    (pair_full),
		.rd_en   (pair_pop),
		.rd_data (pair_rdata),
		.empty   (pair_empty)
	);

	stl_out #(
		.OFFSET_BITS   (OFFSET_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.pair_data     (pair_rdata),
		.pair_empty    (pair_empty),
		.pair_pop      (pair_pop),
		.empty         (empty),
		.pop           (pop),
		.token_kind    (token_kind),
		.status        (status),
		.start_offset  (start_offset),
		.token_length  (token_length),
		.line_number   (line_number),
		.column_number (column_number),
		.last_of_run   (last_of_run)
	);

endmodule
